>>> src/bbcw_pkg.sv
// Shared types and constants for the clipped-window box blur.
package bbcw_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_RADIUS   = 7;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int CFG_W   = 11;
  localparam int POS_W   = 10;

  typedef enum logic [1:0] {
    CFG_RADIUS        = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1,
    CFG_IMAGE_HEIGHT  = 2'd2,
    CFG_CHANNEL_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_START = 6'b010000,
    ST_DIV   = 6'b100000
  } state_t;

  typedef struct packed {
    logic clear;
    logic acc;
    logic start;
  } lane_ctrl_t;

endpackage

>>> src/bbcw_lane.sv
// One channel lane: window sum accumulator and bit-serial divider.
module bbcw_lane #(
  parameter int SW = 16,
  parameter int NW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbcw_pkg::lane_ctrl_t  ctrl,
  input  logic [7:0]            sample,
  input  logic [NW-1:0]         count,
  output logic [7:0]            result,
  output logic                  done
);
  import bbcw_pkg::*;

  localparam int STW = $clog2(SW + 1);

  logic [SW-1:0]  acc;
  logic [SW-1:0]  quo;
  logic [SW-1:0]  quo_next;
  logic [NW-1:0]  rem;
  logic [NW-1:0]  rem_next;
  logic [NW-1:0]  den;
  logic [NW:0]    shifted;
  logic           ge;
  logic [STW-1:0] step;
  logic           busy;

  assign shifted  = {rem, quo[SW-1]};
  assign ge       = shifted >= {1'b0, den};
  assign rem_next = ge ? NW'(shifted - {1'b0, den}) : NW'(shifted);
  assign quo_next = {quo[SW-2:0], ge};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc) begin
      acc <= acc + SW'(sample);
    end
    if (ctrl.start) begin
      quo  <= acc;
      rem  <= '0;
      den  <= count;
      step <= STW'(SW);
    end else if (busy) begin
      quo  <= quo_next;
      rem  <= rem_next;
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (ctrl.start || ctrl.clear) begin
      busy <= ctrl.start;
      done <= 1'b0;
    end else if (busy && step == STW'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  assign result = (quo > SW'(PIX_MAX)) ? 8'(PIX_MAX) : quo[7:0];

endmodule

>>> src/box_blur_clipped_window_core.sv
// Box blur over a (2r+1)-square window clipped to the image, raster in, raster out.
// Pixels are kept in a line store of 2*MAX_RADIUS+2 rows. A pixel that arrives while
// the frame drains is dropped. Any other item is checked and causes an output only
// when its window is complete. An item that releases an output passes through CHECK,
// SUM, FLUSH, START and DIV: SUM reads the N pixels of the clipped window (at most
// (2r+1)^2, one line-store read each through the single read port), and DIV runs a
// bit-serial divide of the SW-bit sum (SW is the sum width, 16 at default size) in
// every channel lane at once. A finished output waits in the output register while
// the next item is taken. Configuration writes restart the frame.
module box_blur_clipped_window_core #(
  parameter int MAX_WIDTH    = bbcw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bbcw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS   = bbcw_pkg::DEF_MAX_RADIUS,
  parameter int MAX_CHANNELS = bbcw_pkg::DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pix_c0, pix_c1, pix_c2, pix_c3
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // blur_c0..blur_c3, out_col, out_row, zero fill
  output logic        m_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import bbcw_pkg::*;

  localparam int S     = 2 * MAX_RADIUS + 2;
  localparam int SLW   = $clog2(S);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH = S * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = PIX_W * MAX_CHANNELS;
  localparam int SIDE  = 2 * MAX_RADIUS + 1;
  localparam int NW    = $clog2(SIDE * SIDE + 1);
  localparam int SW    = $clog2(SIDE * SIDE * PIX_MAX + 1);

  state_t state;

  // Effective (saturated) configuration
  logic [RW-1:0] r;
  logic [CW-1:0] wm1;
  logic [HW-1:0] hm1;
  logic [2:0]    nch;

  logic [CW-1:0]  in_col;
  logic [HW:0]    in_row;
  logic [SLW-1:0] in_slot;
  logic [CW-1:0]  out_x;
  logic [HW-1:0]  out_y;
  logic [SLW-1:0] out_slot;

  logic [CW-1:0]  xs, xe, x_cur;
  logic [HW-1:0]  ys, ye, y_cur;
  logic [SLW-1:0] y_slot;
  logic [NW-1:0]  count;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata;
  logic          rd_valid;

  logic s_fire, cfg_fire, pix_ok;
  logic [CW:0]   xe_raw;
  logic [HW:0]   ye_raw;
  logic [CW-1:0] xe_c, xs_c;
  logic [HW-1:0] ye_c, ys_c;
  logic [SLW-1:0] ys_slot_c;
  logic emit_ok, last_issue, lanes_done, is_last;

  lane_ctrl_t ctrl;
  logic [7:0] lane_res [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] lane_done;

  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign pix_ok    = !s_tuser && (in_row <= {1'b0, hm1});

  // Window bounds for the next output position
  assign xe_raw  = {1'b0, out_x} + (CW+1)'(r);
  assign ye_raw  = {1'b0, out_y} + (HW+1)'(r);
  assign xe_c    = (xe_raw > {1'b0, wm1}) ? wm1 : CW'(xe_raw);
  assign ye_c    = (ye_raw > {1'b0, hm1}) ? hm1 : HW'(ye_raw);
  assign xs_c    = (out_x >= CW'(r)) ? out_x - CW'(r) : '0;
  assign ys_c    = (out_y >= HW'(r)) ? out_y - HW'(r) : '0;
  assign ys_slot_c = (out_y < HW'(r))        ? '0 :
                     (out_slot >= SLW'(r))   ? out_slot - SLW'(r) :
                     SLW'(out_slot + SLW'(S) - SLW'(r));
  assign emit_ok = (in_row > {1'b0, ye_c}) ||
                   (in_row == {1'b0, ye_c} && in_col > xe_c);
  assign last_issue = (y_cur == ye) && (x_cur == xe);
  assign lanes_done = &lane_done;
  assign is_last    = (out_x == wm1) && (out_y == hm1);

  assign ctrl.clear = (state == ST_CHECK);
  assign ctrl.acc   = rd_valid;
  assign ctrl.start = (state == ST_START);

  // Configuration registers, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      r   <= RW'(1);
      wm1 <= CW'(MAX_WIDTH - 1);
      hm1 <= HW'(MAX_HEIGHT - 1);
      nch <= 3'(3);
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_RADIUS:
          r <= (cfg_data[2:0] > 3'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(cfg_data[2:0]);
        CFG_IMAGE_WIDTH:
          wm1 <= (cfg_data == '0) ? '0 :
                 (32'(cfg_data) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(cfg_data - 1'b1);
        CFG_IMAGE_HEIGHT:
          hm1 <= (cfg_data == '0) ? '0 :
                 (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT - 1) : HW'(cfg_data - 1'b1);
        CFG_CHANNEL_COUNT:
          nch <= (cfg_data[2:0] == '0) ? 3'(1) :
                 (cfg_data[2:0] > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (s_fire && pix_ok) begin
      mem[AW'(in_slot * MAX_WIDTH + in_col)] <= s_tdata[DW-1:0];
    end
    if (state == ST_SUM) begin
      rdata <= mem[AW'(y_slot * MAX_WIDTH + x_cur)];
    end
  end

  // Sequencer, position counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_x    <= '0;
      out_y    <= '0;
      out_slot <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SUM);
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_fire) begin
            in_col   <= '0;
            in_row   <= '0;
            in_slot  <= '0;
            out_x    <= '0;
            out_y    <= '0;
            out_slot <= '0;
          end else if (s_fire) begin
            if (pix_ok) begin
              if (in_col == wm1) begin
                in_col  <= '0;
                in_row  <= in_row + 1'b1;
                in_slot <= (in_slot == SLW'(S - 1)) ? '0 : in_slot + 1'b1;
              end else begin
                in_col <= in_col + 1'b1;
              end
            end
            // drop a pixel that arrives while the frame drains
            state <= (s_tuser || pix_ok) ? ST_CHECK : ST_IDLE;
          end
        end
        ST_CHECK: begin
          if (emit_ok) begin
            xs     <= xs_c;
            xe     <= xe_c;
            ys     <= ys_c;
            ye     <= ye_c;
            x_cur  <= xs_c;
            y_cur  <= ys_c;
            y_slot <= ys_slot_c;
            state  <= ST_SUM;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SUM: begin
          count <= NW'((ye - ys + 1'b1) * (xe - xs + 1'b1));
          if (last_issue) begin
            state <= ST_FLUSH;
          end else if (x_cur == xe) begin
            x_cur  <= xs;
            y_cur  <= y_cur + 1'b1;
            y_slot <= (y_slot == SLW'(S - 1)) ? '0 : y_slot + 1'b1;
          end else begin
            x_cur <= x_cur + 1'b1;
          end
        end
        ST_FLUSH: state <= ST_START;
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (lanes_done && !m_tvalid) begin
            m_tvalid <= 1'b1;
            for (int c = 0; c < 4; c++) begin
              if (c < MAX_CHANNELS && 3'(c) < nch) begin
                m_tdata[8*c +: 8] <= lane_res[c % MAX_CHANNELS];
              end else begin
                m_tdata[8*c +: 8] <= '0;
              end
            end
            m_tdata[41:32] <= POS_W'(out_x);
            m_tdata[51:42] <= POS_W'(out_y);
            m_tdata[55:52] <= '0;
            m_tlast        <= is_last;
            if (is_last) begin
              in_col   <= '0;
              in_row   <= '0;
              in_slot  <= '0;
              out_x    <= '0;
              out_y    <= '0;
              out_slot <= '0;
            end else if (out_x == wm1) begin
              out_x    <= '0;
              out_y    <= out_y + 1'b1;
              out_slot <= (out_slot == SLW'(S - 1)) ? '0 : out_slot + 1'b1;
            end else begin
              out_x <= out_x + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    bbcw_lane #(
      .SW(SW),
      .NW(NW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .sample(rdata[8*g +: 8]),
      .count (count),
      .result(lane_res[g]),
      .done  (lane_done[g])
    );
  end

  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    in_col <= wm1) else $error("input column past row end");
  a_out_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_x <= wm1 && out_y <= hm1) else $error("output position outside frame");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && lanes_done && !m_tvalid) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished result not loaded");
  a_sum_enters_from_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && $past(state) != ST_SUM) |-> $past(state) == ST_CHECK)
    else $error("window sweep started without a check");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the clipped-window box blur core.
module tb_top;
  import bbcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = 2 * DEF_MAX_RADIUS + 2;
  localparam int LAT_WAIT   = 300;
  localparam int ITEM_GOAL  = 1250;

  typedef struct packed {
    bit       last;
    bit [9:0] row;
    bit [9:0] col;
    bit [3:0][7:0] avg;
  } blur_pix_t;

  class box_blur_predictor;
    bit [31:0] line_mem [STORE_ROWS * DEF_MAX_WIDTH];
    bit [2:0]  radius_reg;
    bit [10:0] width_reg;
    bit [10:0] height_reg;
    bit [2:0]  chan_reg;
    int unsigned in_col, in_row, out_col, out_row;
    blur_pix_t pending_blur[$];
    int errors;

    function new();
      radius_reg = 3'd1;
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      chan_reg   = 3'd3;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_w();
      return width_reg == 0 ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
    endfunction

    function int unsigned eff_h();
      return height_reg == 0 ? 1 : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
    endfunction

    function bit draining();
      return in_row >= eff_h();
    endfunction

    function void note_config(cfg_idx_t idx, bit [10:0] value);
      case (idx)
        CFG_RADIUS:        radius_reg = value[2:0];
        CFG_IMAGE_WIDTH:   width_reg  = value;
        CFG_IMAGE_HEIGHT:  height_reg = value;
        CFG_CHANNEL_COUNT: chan_reg   = value[2:0];
        default: ;
      endcase
      restart();
    endfunction

    // Returns 0 when the item is a pixel dropped during draining.
    function bit note_input(bit op, bit [31:0] px);
      int unsigned w, h;
      w = eff_w();
      h = eff_h();
      if (!op) begin
        if (in_row >= h || in_col >= w) return 0;
        line_mem[(in_row % STORE_ROWS) * DEF_MAX_WIDTH + in_col] = px;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      predict_blur();
      return 1;
    endfunction

    function void predict_blur();
      int unsigned w, h, r, nch, xs, xe, ys, ye, cnt;
      int unsigned sum [4];
      bit [31:0] word;
      blur_pix_t res;
      w = eff_w();
      h = eff_h();
      r = radius_reg;
      nch = chan_reg == 0 ? 1 : (chan_reg > DEF_MAX_CHANNELS ? DEF_MAX_CHANNELS : chan_reg);
      if (out_col >= w || out_row >= h) return;
      ye = (out_row + r > h - 1) ? h - 1 : out_row + r;
      xe = (out_col + r > w - 1) ? w - 1 : out_col + r;
      if (!(in_row > ye || (in_row == ye && in_col > xe))) return;
      ys = out_row >= r ? out_row - r : 0;
      xs = out_col >= r ? out_col - r : 0;
      for (int c = 0; c < 4; c++) sum[c] = 0;
      for (int unsigned y = ys; y <= ye; y++)
        for (int unsigned x = xs; x <= xe; x++) begin
          word = line_mem[(y % STORE_ROWS) * DEF_MAX_WIDTH + x];
          for (int c = 0; c < 4; c++) sum[c] += word[8*c +: 8];
        end
      cnt = (ye - ys + 1) * (xe - xs + 1);
      for (int c = 0; c < 4; c++)
        res.avg[c] = (c < nch) ? 8'(sum[c] / cnt) : 8'd0;
      res.col  = out_col[9:0];
      res.row  = out_row[9:0];
      res.last = (out_col == w - 1 && out_row == h - 1);
      pending_blur.push_back(res);
      if (res.last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(bit [55:0] data, bit last);
      blur_pix_t got, exp_pix;
      got.avg  = data[31:0];
      got.col  = data[41:32];
      got.row  = data[51:42];
      got.last = last;
      if (pending_blur.size() == 0) begin
        $display("%0t: output with none pending: col %0d row %0d", $realtime, got.col, got.row);
        errors++;
        return;
      end
      exp_pix = pending_blur.pop_front();
      for (int c = 0; c < 4; c++)
        if (got.avg[c] !== exp_pix.avg[c]) begin
          $display("%0t: blur_c%0d expected %0d actual %0d", $realtime, c,
                   exp_pix.avg[c], got.avg[c]);
          errors++;
        end
      if (got.col !== exp_pix.col) begin
        $display("%0t: out_col expected %0d actual %0d", $realtime, exp_pix.col, got.col);
        errors++;
      end
      if (got.row !== exp_pix.row) begin
        $display("%0t: out_row expected %0d actual %0d", $realtime, exp_pix.row, got.row);
        errors++;
      end
      if (got.last !== exp_pix.last) begin
        $display("%0t: frame_end expected %0d actual %0d", $realtime, exp_pix.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  box_blur_predictor pred = new();
  int  items_sent = 0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;
  int  sink_hold = 0;

  box_blur_clipped_window_core uut (.*);

  always #5 clk = ~clk;

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (sink_steady) begin
      m_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      int g;
      g = rand_gap();
      m_tready <= (g == 0);
      sink_hold <= (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) pred.check_result(m_tdata, m_tlast);
  end

  task automatic send_item(bit op, bit [31:0] px);
    int g;
    g = src_steady ? 0 : rand_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    if (pred.note_input(op, px)) items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    pred.note_config(idx, value);
  endtask

  // Wait for the block to go idle, then load all four registers.
  task automatic program_regs(bit [10:0] r, bit [10:0] w, bit [10:0] h, bit [10:0] ch);
    s_tvalid <= 1'b0;
    while (pred.pending_blur.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CHANNEL_COUNT, ch);
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_pixels(int n);
    int i;
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'b1, $urandom());
      end else begin
        send_item(1'b0, $urandom());
        i++;
      end
    end
  endtask

  task automatic drain_frame();
    while (pred.draining()) begin
      if ($urandom_range(0, 4) == 0) send_item(1'b0, $urandom());
      else send_item(1'b1, $urandom());
    end
    if ($urandom_range(0, 1) == 0) send_item(1'b1, $urandom());
  endtask

  initial begin
    int area;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: extremes, then a drain with nothing ready
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hA5A5_5A5A);
    send_item(1'b1, 32'h0);
    // zero-valued registers clamp to a 1x1 image, one channel
    program_regs(11'd0, 11'd0, 11'd0, 11'd0);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b1, 32'h0);
    send_item(1'b0, 32'h0102_0304);
    // window larger than the image, channel count above range
    program_regs(11'd7, 11'd3, 11'd2, 11'd7);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b1, 32'h0);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h8040_2010);
    send_item(1'b0, 32'hDEAD_BEEF);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);

    // width and height above range, partial frames only
    program_regs(11'd7, 11'd2047, 11'd1, 11'd4);
    stream_pixels(30);
    program_regs(11'd7, 11'd1, 11'd2047, 11'd2);
    stream_pixels(30);

    while (items_sent < ITEM_GOAL) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      program_regs(11'($urandom_range(0, 7)), 11'($urandom_range(0, 12)),
                   11'($urandom_range(0, 12)), 11'($urandom_range(0, 7)));
      area = pred.eff_w() * pred.eff_h();
      if ($urandom_range(0, 9) < 7) begin
        stream_pixels(area);
        drain_frame();
      end else begin
        stream_pixels(area > 1 ? $urandom_range(1, area - 1) : 1);
      end
    end

    s_tvalid <= 1'b0;
    while (pred.pending_blur.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    if (pred.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
src/bbcw_pkg.sv
src/bbcw_lane.sv
src/box_blur_clipped_window_core.sv
verif/tb_top.sv
